>>> hw/rtl/colonization_transition_probability_core_macros.svh
// Assertion macros shared by the RTL of the colonization transition core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef COLONIZATION_TRANSITION_PROBABILITY_CORE_MACROS_SVH
`define COLONIZATION_TRANSITION_PROBABILITY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define CTP_ASSERT_HOLD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CTP_ASSERT_HOLD(label, clk, rst_n, prop, msg)
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/ctp_pkg.sv
`default_nettype none

package ctp_pkg;

	// Default number of habitat patches.
	localparam int unsigned PATCHES_DEF = 8;

	// Fixed field widths.
	localparam int unsigned OCC_W     = 8;
	localparam int unsigned OCC_IDX_W = $clog2(OCC_W);
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned PROB_W    = 17;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Coupling sum: up to seven Q0.16 terms plus a source term below 2^24.
	localparam int unsigned SUM_W  = 25;
	// Shared multiplier: 17-bit by 25-bit operands.
	localparam int unsigned MUL_AW = 17;
	localparam int unsigned PROD_W = MUL_AW + SUM_W;

	localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

	// Function codes of an input item.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0]     RATE_RESET   = CFG_W'(4096);
	localparam logic [CFG_W-1:0]     SOURCE_RESET = CFG_W'(0);

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_PATCH,
		S_SUM,
		S_SRC,
		S_SRCW,
		S_RATE,
		S_CLAMP,
		S_FAC,
		S_ACC,
		S_DONE
	} ctp_state_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_SRC,
		MUL_RATE,
		MUL_ACC
	} ctp_mul_sel_t;

	// Controls from the sequencer to the arithmetic unit.
	typedef struct packed {
		ctp_mul_sel_t mul_sel;
		logic         mul_en;
		logic         sum_clr;
		logic         sum_add_tab;
		logic         sum_add_src;
		logic         fac_load;
		logic         acc_init;
		logic         acc_load;
	} ctp_op_t;

	// Occupancy of one patch; patches beyond the mask are always empty.
	function automatic logic occ_bit(input logic [OCC_W-1:0] mask, input int unsigned idx);
		logic bit_v;
		bit_v = 1'b0;
		if (idx < OCC_W) begin
			bit_v = mask[idx[OCC_IDX_W-1:0]];
		end
		return bit_v;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctp_arith.sv
`default_nettype none

module ctp_arith import ctp_pkg::*; (
	input  wire logic              clk,
	input  wire ctp_op_t           op,
	input  wire logic [COEF_W-1:0] tab_coef,
	input  wire logic [CFG_W-1:0]  rate,
	input  wire logic [CFG_W-1:0]  source,
	input  wire logic              now_occ,
	output logic      [PROB_W-1:0] acc
);

	logic [MUL_AW-1:0]  mul_a;
	logic [SUM_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PROB_W-1:0]  factor_q;
	logic [PROB_W-1:0]  acc_q;
	logic [PROD_W-13:0] scaled;
	logic [PROB_W-1:0]  chance;

	// Operand selection for the one shared multiplier.
	always_comb begin
		unique case (op.mul_sel)
			MUL_SRC: begin
				mul_a = MUL_AW'(tab_coef);
				mul_b = SUM_W'(source);
			end
			MUL_RATE: begin
				mul_a = MUL_AW'(rate);
				mul_b = sum_q;
			end
			MUL_ACC: begin
				mul_a = acc_q;
				mul_b = SUM_W'(factor_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rate times coupling sum, back to Q.16 and clamped to one.
	assign scaled = prod_q[PROD_W-1:12];
	assign chance = (scaled > (PROD_W-12)'(ONE_Q16)) ? ONE_Q16 : scaled[PROB_W-1:0];

	// Product register; every multiply lands here before it is used.
	always_ff @(posedge clk) begin
		if (op.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// Coupling sum accumulator.
	always_ff @(posedge clk) begin
		if (op.sum_clr) begin
			sum_q <= '0;
		end else if (op.sum_add_tab) begin
			sum_q <= sum_q + SUM_W'(tab_coef);
		end else if (op.sum_add_src) begin
			sum_q <= sum_q + SUM_W'(prod_q[31:8]);
		end
	end

	// Factor of the current patch: the chance, or its complement.
	always_ff @(posedge clk) begin
		if (op.fac_load) begin
			factor_q <= now_occ ? chance : (ONE_Q16 - chance);
		end
	end

	// Running product of the factors, truncated to Q1.16 at each step.
	always_ff @(posedge clk) begin
		if (op.acc_init) begin
			acc_q <= ONE_Q16;
		end else if (op.acc_load) begin
			acc_q <= prod_q[32:16];
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/colonization_transition_probability_core.sv
// Colonization transition probability core.
// Input channel (in_valid / in_stall): a transfer with func = 0 writes one Q0.16
// coupling coefficient at (row, col); row PATCHES is the external source row.
// A load gives no result. A transfer with func = 1 evaluates the pair
// old_occupancy / new_occupancy and gives one result on the output channel
// (out_valid / out_stall): probability in Q1.16 and the impossible flag.
// An evaluation runs one patch at a time on a single shared multiplier. An
// occupied patch only advances the patch counter; an empty patch makes
// PATCHES + 1 table reads from the single read port, then source, rate,
// clamp and product steps. After the last patch the sequencer moves to S_DONE,
// which loads the output register. A pair where an occupied patch becomes
// empty skips the patch steps and goes from idle straight to S_DONE.
// in_stall is high from the accepted evaluate transfer until
// its result sits in the output register. A waiting result holds while
// out_stall is high, and the sequencer waits with the next result until the
// output register is free. Reset clears the sequencer and the output valid and
// sets colonization_rate to 1.0 and source_strength to 0; the coupling table
// is not cleared and each entry must be loaded before it is read.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once.
`default_nettype none

`include "colonization_transition_probability_core_macros.svh"

module colonization_transition_probability_core import ctp_pkg::*; #(
	parameter int unsigned PATCHES = PATCHES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	// Input channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 func,
	input  wire logic [3:0]           row,
	input  wire logic [2:0]           col,
	input  wire logic [COEF_W-1:0]    coefficient,
	input  wire logic [OCC_W-1:0]     old_occupancy,
	input  wire logic [OCC_W-1:0]     new_occupancy,
	// Output channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [PROB_W-1:0]    probability,
	output logic                      impossible
);

	localparam int unsigned DEPTH  = (PATCHES + 1) * PATCHES;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(PATCHES + 1);

	ctp_state_t         state_q;
	ctp_state_t         state_d;
	ctp_op_t            op;
	logic [CFG_W-1:0]   rate_q;
	logic [CFG_W-1:0]   source_q;
	logic [OCC_W-1:0]   old_q;
	logic [OCC_W-1:0]   new_q;
	logic               imp_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   l_q;
	logic [CNT_W-1:0]   rd_l_q;
	logic               rd_vld_q;
	logic [COEF_W-1:0]  coupling_mem [DEPTH];
	logic [COEF_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_en;
	logic               tab_we;
	logic               in_xfer;
	logic               breaks;
	logic               was_occ;
	logic               now_occ;
	logic               k_end;
	logic               l_end;
	logic               out_load;
	logic               out_valid_q;
	logic [PROB_W-1:0]  probability_q;
	logic               impossible_q;
	logic [PROB_W-1:0]  acc;

	// Handshake and per-item decode.
	assign in_xfer = in_valid && !in_stall;
	assign breaks  = (old_occupancy & ~new_occupancy) != '0;
	assign tab_we  = in_xfer && (func == FUNC_LOAD) && (32'(row) <= PATCHES)
		&& (32'(col) < PATCHES);
	assign was_occ = occ_bit(old_q, 32'(k_q));
	assign now_occ = occ_bit(new_q, 32'(k_q));
	assign k_end   = 32'(k_q) == PATCHES;
	assign l_end   = 32'(l_q) == PATCHES;
	assign wr_addr = ADDR_W'(32'(row) * PATCHES + 32'(col));
	assign rd_addr = ADDR_W'(32'(l_q) * PATCHES + 32'(k_q));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_RESET;
			source_q <= SOURCE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RATE:   rate_q   <= wr_data;
				REG_SOURCE: source_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Coupling table with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (tab_we) begin
			coupling_mem[wr_addr] <= coefficient;
		end
		if (rd_en) begin
			rd_data_q <= coupling_mem[rd_addr];
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && (func == FUNC_EVAL)) begin
					state_d = breaks ? S_DONE : S_PATCH;
				end
			end
			S_PATCH: begin
				if (k_end) begin
					state_d = S_DONE;
				end else if (!was_occ) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (l_end) begin
					state_d = S_SRC;
				end
			end
			S_SRC:   state_d = S_SRCW;
			S_SRCW:  state_d = S_RATE;
			S_RATE:  state_d = S_CLAMP;
			S_CLAMP: state_d = S_FAC;
			S_FAC:   state_d = S_ACC;
			S_ACC:   state_d = S_PATCH;
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output logic of the sequencer: datapath controls and handshakes.
	always_comb begin
		op          = '0;
		op.mul_sel  = MUL_SRC;
		rd_en       = 1'b0;
		out_load    = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				op.acc_init = 1'b1;
			end
			S_PATCH: begin
				op.sum_clr = 1'b1;
			end
			S_SUM: begin
				rd_en = 1'b1;
				op.sum_add_tab = rd_vld_q && occ_bit(old_q, 32'(rd_l_q)) && (rd_l_q != k_q);
			end
			S_SRC: begin
				op.mul_sel = MUL_SRC;
				op.mul_en  = 1'b1;
			end
			S_SRCW: begin
				op.sum_add_src = 1'b1;
			end
			S_RATE: begin
				op.mul_sel = MUL_RATE;
				op.mul_en  = 1'b1;
			end
			S_CLAMP: begin
				op.fac_load = 1'b1;
			end
			S_FAC: begin
				op.mul_sel = MUL_ACC;
				op.mul_en  = 1'b1;
			end
			S_ACC: begin
				op.acc_load = 1'b1;
			end
			S_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	// Patch and table-row counters, and the read pipeline tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			l_q      <= '0;
			rd_l_q   <= '0;
			rd_vld_q <= 1'b0;
			imp_q    <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == S_SUM) && !l_end;
			rd_l_q   <= l_q;
			if (state_q == S_IDLE) begin
				k_q <= '0;
				if (in_xfer && (func == FUNC_EVAL)) begin
					imp_q <= breaks;
				end
			end else if ((state_q == S_PATCH) && !k_end && was_occ) begin
				k_q <= k_q + 1'b1;
			end else if (state_q == S_ACC) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == S_PATCH) begin
				l_q <= '0;
			end else if ((state_q == S_SUM) && !l_end) begin
				l_q <= l_q + 1'b1;
			end
		end
	end

	// Occupancy masks of the item at work.
	always_ff @(posedge clk) begin
		if (in_xfer && (func == FUNC_EVAL)) begin
			old_q <= old_occupancy;
			new_q <= new_occupancy;
		end
	end

	// Shared arithmetic unit.
	ctp_arith u_arith (
		.clk      (clk),
		.op       (op),
		.tab_coef (rd_data_q),
		.rate     (rate_q),
		.source   (source_q),
		.now_occ  (now_occ),
		.acc      (acc)
	);

	// Output register; a result waits here while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			probability_q <= imp_q ? '0 : acc;
			impossible_q  <= imp_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign probability = probability_q;
	assign impossible  = impossible_q;

	// Checks on the datapath and the sequencer.
	`CTP_ASSERT_HOLD(a_imp_zero, clk, arst_n, !(out_valid_q && impossible_q && (probability_q != '0)), "impossible result with nonzero probability")
	`CTP_ASSERT_HOLD(a_prob_max, clk, arst_n, !out_valid_q || (probability_q <= ONE_Q16), "probability above one")
	`CTP_ASSERT_HOLD(a_sum_patch, clk, arst_n, (state_q != S_SUM) || (32'(k_q) < PATCHES), "coupling sum on a patch past the last")
	`CTP_ASSERT_NEXT(a_acc_step, clk, arst_n, state_q == S_ACC, (state_q == S_PATCH) && (k_q == $past(k_q) + 1'b1), "patch counter did not advance after product step")

endmodule

`default_nettype wire

>>> sim/colonization_transition_probability_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the colonization
// transition core. It keeps its own copy of the coupling table and the
// registers, predicts each evaluation, and compares results in order.
module colonization_transition_probability_checker import ctp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic                 func,
	input  wire logic [3:0]           row,
	input  wire logic [2:0]           col,
	input  wire logic [COEF_W-1:0]    coefficient,
	input  wire logic [OCC_W-1:0]     old_occupancy,
	input  wire logic [OCC_W-1:0]     new_occupancy,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [PROB_W-1:0]    probability,
	input  wire logic                 impossible,
	output int                        pending,
	output int                        errors,
	output int                        checked
);

	localparam int unsigned NP = PATCHES_DEF;
	localparam longint unsigned UNITY = 65536;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic              impossible;
	} transition_t;

	logic [COEF_W-1:0] coupling [NP+1][NP];
	logic [CFG_W-1:0]  rate_q412;
	logic [CFG_W-1:0]  source_q88;
	transition_t       pending_transitions [$];

	// Chance that the empty patch k is colonized, in Q1.16, clamped to one.
	function automatic longint unsigned colonize_chance(input logic [OCC_W-1:0] occ,
			input int unsigned k);
		longint unsigned coupling_sum;
		longint unsigned source_term;
		longint unsigned rate_wide;
		longint unsigned scaled;
		int unsigned     l;
		coupling_sum = 0;
		for (l = 0; l < NP; l++) begin
			if (l != k && occ[l]) begin
				coupling_sum += coupling[l][k];
			end
		end
		source_term = coupling[NP][k];
		coupling_sum += (source_term * source_q88) >> 8;
		rate_wide = rate_q412;
		scaled = (rate_wide * coupling_sum) >> 12;
		if (scaled > UNITY) begin
			scaled = UNITY;
		end
		return scaled;
	endfunction

	// Probability of going from one occupancy mask to the other.
	function automatic transition_t predict_transition(input logic [OCC_W-1:0] before_occ,
			input logic [OCC_W-1:0] after_occ);
		transition_t     res;
		longint unsigned prod;
		longint unsigned chance;
		longint unsigned factor;
		int unsigned     k;
		res.probability = '0;
		res.impossible  = 1'b1;
		if ((before_occ & ~after_occ) == '0) begin
			prod = UNITY;
			for (k = 0; k < NP; k++) begin
				if (before_occ[k]) begin
					factor = UNITY;
				end else begin
					chance = colonize_chance(before_occ, k);
					factor = after_occ[k] ? chance : UNITY - chance;
				end
				prod = (prod * factor) >> 16;
			end
			res.probability = PROB_W'(prod);
			res.impossible  = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		transition_t want;
		if (!arst_n) begin
			rate_q412  = RATE_RESET;
			source_q88 = SOURCE_RESET;
			pending_transitions.delete();
			pending = 0;
			errors  = 0;
			checked = 0;
		end else begin
			// Result transfer: compare with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (pending_transitions.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, probability %0d impossible %0b",
						$time, probability, impossible);
				end else begin
					want = pending_transitions.pop_front();
					checked++;
					if (probability !== want.probability) begin
						errors++;
						$display("%0t: probability expected %0d, got %0d",
							$time, want.probability, probability);
					end
					if (impossible !== want.impossible) begin
						errors++;
						$display("%0t: impossible flag expected %0b, got %0b",
							$time, want.impossible, impossible);
					end
				end
			end

			// Input transfer: a load updates the table, an evaluation is predicted.
			if (in_valid && !in_stall) begin
				if (func == FUNC_LOAD) begin
					if (row <= NP) begin
						coupling[row][col] = coefficient;
					end
				end else begin
					pending_transitions.push_back(
						predict_transition(old_occupancy, new_occupancy));
				end
			end

			// Register writes; spare indexes have no effect.
			if (wr_en) begin
				case (wr_index)
					REG_RATE: begin
						rate_q412 = wr_data;
					end
					REG_SOURCE: begin
						source_q88 = wr_data;
					end
					default: begin
					end
				endcase
			end
			pending = pending_transitions.size();
		end
	end

endmodule

>>> sim/colonization_transition_probability_core_tb.sv
`timescale 1ns / 100ps

module colonization_transition_probability_core_tb;
	import ctp_pkg::*;

	localparam int unsigned NP = PATCHES_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	// Wait well past the longest evaluation.
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 91;
	localparam int PHASES = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	typedef enum int {
		PACE_FREE,
		PACE_SENDER,
		PACE_RECEIVER,
		PACE_BOTH,
		PACE_HOLD
	} pace_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 func;
	logic [3:0]           row;
	logic [2:0]           col;
	logic [COEF_W-1:0]    coefficient;
	logic [OCC_W-1:0]     old_occupancy;
	logic [OCC_W-1:0]     new_occupancy;
	logic                 out_valid;
	logic                 out_stall;
	logic [PROB_W-1:0]    probability;
	logic                 impossible;

	int mismatches;
	int outstanding;
	int results_checked;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off_armed;
	int cycle_count = 0;
	int n_loads = 0;
	int n_evals = 0;
	int n_impossible = 0;

	colonization_transition_probability_core #(
		.PATCHES(NP)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.row          (row),
		.col          (col),
		.coefficient  (coefficient),
		.old_occupancy(old_occupancy),
		.new_occupancy(new_occupancy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.probability  (probability),
		.impossible   (impossible)
	);

	colonization_transition_probability_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.row          (row),
		.col          (col),
		.coefficient  (coefficient),
		.old_occupancy(old_occupancy),
		.new_occupancy(new_occupancy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.probability  (probability),
		.impossible   (impossible),
		.pending      (outstanding),
		.errors       (mismatches),
		.checked      (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding",
				outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Output side: random stalls, or one long hold-off when armed.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Offers one item and returns at the falling edge after its transfer.
	task automatic send_item(input logic f, input logic [3:0] r, input logic [2:0] c,
			input logic [COEF_W-1:0] coef, input logic [OCC_W-1:0] before_occ,
			input logic [OCC_W-1:0] after_occ);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		row           <= r;
		col           <= c;
		coefficient   <= coef;
		old_occupancy <= before_occ;
		new_occupancy <= after_occ;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
	endtask

	// Coupling values spread over several magnitudes so that sums do not
	// always saturate.
	function automatic logic [COEF_W-1:0] random_coupling();
		return COEF_W'($urandom_range(0, 65535) >> $urandom_range(0, 6));
	endfunction

	task automatic load_coupling(input logic [3:0] r, input logic [2:0] c,
			input logic [COEF_W-1:0] coef);
		n_loads++;
		send_item(FUNC_LOAD, r, c, coef, OCC_W'($urandom_range(0, 255)),
			OCC_W'($urandom_range(0, 255)));
	endtask

	task automatic evaluate(input logic [OCC_W-1:0] before_occ,
			input logic [OCC_W-1:0] after_occ);
		n_evals++;
		if ((before_occ & ~after_occ) != '0) begin
			n_impossible++;
		end
		send_item(FUNC_EVAL, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
			COEF_W'($urandom_range(0, 65535)), before_occ, after_occ);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Stops offering, waits for every result and lets the core go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_pace(input pace_t pace);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		case (pace)
			PACE_SENDER: begin
				send_idle_pct = 71;
			end
			PACE_RECEIVER: begin
				recv_stall_pct = 71;
			end
			PACE_BOTH: begin
				send_idle_pct  = 13;
				recv_stall_pct = 13;
			end
			PACE_HOLD: begin
				hold_off_armed = 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	// One load in four; otherwise mostly legal transitions (patches only gain occupancy), some raw pairs.
	task automatic random_item();
		logic [OCC_W-1:0] before_occ;
		logic [OCC_W-1:0] after_occ;
		if ($urandom_range(0, 99) < 25) begin
			load_coupling(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
				random_coupling());
		end else begin
			before_occ = OCC_W'($urandom_range(0, 255));
			if ($urandom_range(0, 1) == 1) begin
				before_occ &= OCC_W'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 99) < 85) begin
				after_occ = before_occ | (OCC_W'($urandom_range(0, 255)) &
					OCC_W'($urandom_range(0, 255)));
			end else begin
				after_occ = OCC_W'($urandom_range(0, 255));
			end
			evaluate(before_occ, after_occ);
		end
	endtask

	initial begin
		int r;
		int c;
		int ph;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_RATE;
		wr_data       = '0;
		in_valid      = 1'b0;
		func          = FUNC_LOAD;
		row           = '0;
		col           = '0;
		coefficient   = '0;
		old_occupancy = '0;
		new_occupancy = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_armed = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the whole coupling table, source row included, before any evaluation.
		for (r = 0; r <= NP; r++) begin
			for (c = 0; c < NP; c++) begin
				load_coupling(4'(r), 3'(c), random_coupling());
			end
		end

		// Directed cases at the reset rate of one and no source.
		evaluate(8'h00, 8'h00);
		evaluate(8'hff, 8'hff);
		evaluate(8'h00, 8'hff);
		// Occupied patches going empty, then more legal pairs.
		evaluate(8'h01, 8'h00);
		evaluate(8'hff, 8'h00);
		evaluate(8'h80, 8'h7f);
		evaluate(8'h01, 8'h03);
		evaluate(8'h0f, 8'h1f);
		evaluate(8'h55, 8'hff);
		evaluate(8'haa, 8'haa);
		// Rows past the source row must leave the table alone; then four entries are overwritten, two in the source row.
		load_coupling(4'd9, 3'd0, 16'hffff);
		load_coupling(4'd15, 3'd7, 16'hffff);
		load_coupling(4'd3, 3'd4, 16'hffff);
		load_coupling(4'd0, 3'd0, 16'hffff);
		load_coupling(4'(NP), 3'd2, 16'hffff);
		load_coupling(4'(NP), 3'd7, 16'h0000);
		evaluate(8'h08, 8'h18);
		evaluate(8'h08, 8'h08);
		evaluate(8'hfe, 8'hff);
		evaluate(8'h7f, 8'hff);
		evaluate(8'h01, 8'h01);
		settle();

		// Random phases, each under its own register setting and pacing.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_register(REG_RATE, 16'hffff);
					write_register(REG_SOURCE, 16'hffff);
				end
				1: begin
					write_register(REG_RATE, 16'h0000);
					write_register(REG_SOURCE, 16'h0000);
				end
				2: begin
					write_register(REG_RATE, CFG_W'($urandom_range(0, 65535)));
					write_register(REG_SOURCE, CFG_W'($urandom_range(0, 65535)));
				end
				3: begin
					write_register(REG_RATE, CFG_W'($urandom_range(0, 8192)));
					write_register(REG_SOURCE, CFG_W'($urandom_range(0, 1024)));
				end
				default: begin
					write_register(REG_RATE, 16'h1000);
					write_register(REG_SOURCE, 16'h0100);
				end
			endcase
			write_register(ph[0] ? REG_SPARE_HI : REG_SPARE_LO,
				CFG_W'($urandom_range(0, 65535)));
			set_pace(pace_t'(ph));
			repeat (PHASE_ITEMS) random_item();
			settle();
		end

		$display("Covered %0d coupling loads and %0d evaluations (%0d impossible), %0d checked,",
			n_loads, n_evals, n_impossible, results_checked);
		$display("across five rate/source settings, four pacing patterns and a long output hold.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
